### hdl/sacl_pkg.sv
// Shared types of the set-associative cache tag block.
// No dependencies; imported by sacl_front, sacl_back, the top level and the testbench.
package sacl_pkg;

    localparam int ADDR_W = 32;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [1:0]        way_used;
        logic              fetch_valid;
        logic [ADDR_W-1:0] fetch_address;
        logic              evict_valid;
        logic [ADDR_W-1:0] evict_address;
        logic              mem_write_valid;
        logic [ADDR_W-1:0] mem_write_address;
    } t_result;

    localparam logic OP_WRITE = 1'b1;
    localparam logic POLICY_WRITE_THROUGH = 1'b1;

endpackage

### hdl/sacl_fifo.sv
// Two-entry queue of fixed-width beats.
// Depends on nothing; used for the request and result queues.
module sacl_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

### hdl/sacl_front.sv
// Front end: request queue and address split into set, tag and block.
// Depends on sacl_pkg and sacl_fifo.
module sacl_front import sacl_pkg::*; #(
    parameter int OFFSET_BITS = 4,
    parameter int SB          = 6,
    parameter int IW          = 6,
    parameter int TW          = 22
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_op,
    input  logic [ADDR_W-1:0] i_address,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_op,
    output logic [IW-1:0]     o_set,
    output logic [TW-1:0]     o_tag,
    output logic [ADDR_W-1:0] o_block
);
    localparam int LO = OFFSET_BITS + SB;

    t_req in_req;
    t_req head;
    logic [ADDR_W-1:0] set_mask;
    logic [ADDR_W-1:0] off_mask;

    assign in_req.op      = i_op;
    assign in_req.address = i_address;

    sacl_fifo #(.WIDTH($bits(t_req))) u_reqq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (in_req),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (head)
    );

    assign set_mask = (ADDR_W'(1) << SB) - ADDR_W'(1);
    assign off_mask = (ADDR_W'(1) << OFFSET_BITS) - ADDR_W'(1);
    assign o_op     = head.op;
    assign o_set    = IW'((head.address >> OFFSET_BITS) & set_mask);
    assign o_tag    = TW'(head.address >> LO);
    assign o_block  = head.address & ~off_mask;
endmodule

### hdl/sacl_back.sv
// Back end: tag and stamp memories, LRU victim choice and state update.
// Depends on sacl_pkg; fed by sacl_front, feeds the result queue.
module sacl_back import sacl_pkg::*; #(
    parameter int OFFSET_BITS = 4,
    parameter int SB          = 6,
    parameter int IW          = 6,
    parameter int TW          = 22,
    parameter int WAYS        = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_policy,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_op,
    input  logic [IW-1:0]     i_set,
    input  logic [TW-1:0]     i_tag,
    input  logic [ADDR_W-1:0] i_block,
    input  logic              i_out_full,
    output logic              o_out_push,
    output t_result           o_result
);
    localparam int ROWS = 1 << SB;
    localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LO   = OFFSET_BITS + SB;

    typedef enum logic {S_IDLE, S_UP} t_state;

    t_state            r_state;
    logic [TW-1:0]     mem_tag   [ROWS][WAYS];
    logic [31:0]       mem_stamp [ROWS][WAYS];
    logic              r_valid   [ROWS][WAYS];
    logic              r_dirty   [ROWS][WAYS];
    logic [TW-1:0]     r_tag_row   [WAYS];
    logic [31:0]       r_stamp_row [WAYS];
    logic              r_op;
    logic [IW-1:0]     r_set;
    logic [TW-1:0]     r_tag;
    logic [ADDR_W-1:0] r_block;
    logic [31:0]       r_clock;

    logic              hit;
    logic              found_inv;
    logic [WW-1:0]     hit_way;
    logic [WW-1:0]     inv_way;
    logic [WW-1:0]     lru_way;
    logic [WW-1:0]     way;
    logic [31:0]       best;
    logic              vic_dirty;
    logic              new_dirty;
    logic              is_wr;
    logic [IW-1:0]     row;

    assign row        = IW'(r_set & IW'(ROWS - 1));
    assign is_wr      = (r_op == OP_WRITE);
    assign o_pop      = (r_state == S_IDLE) && !i_empty && !i_out_full;
    assign o_out_push = (r_state == S_UP);

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        found_inv = 1'b0;
        inv_way   = '0;
        lru_way   = '0;
        best      = r_stamp_row[0];
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_valid[row][w] && r_tag_row[w] == r_tag) begin
                hit     = 1'b1;
                hit_way = WW'(w);
            end
            if (!r_valid[row][w]) begin
                found_inv = 1'b1;
                inv_way   = WW'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            if (r_stamp_row[w] < best) begin
                best    = r_stamp_row[w];
                lru_way = WW'(w);
            end
        end
        way       = hit ? hit_way : (found_inv ? inv_way : lru_way);
        vic_dirty = !hit && r_valid[row][way] && r_dirty[row][way];
        new_dirty = (is_wr && i_policy != POLICY_WRITE_THROUGH) ? 1'b1
                  : (hit ? r_dirty[row][way] : 1'b0);
        o_result.hit               = hit;
        o_result.way_used          = 2'(way);
        o_result.fetch_valid       = !hit;
        o_result.fetch_address     = hit ? '0 : r_block;
        o_result.evict_valid       = vic_dirty;
        o_result.evict_address     = vic_dirty
            ? ((ADDR_W'(r_tag_row[way]) << LO) | (ADDR_W'(r_set) << OFFSET_BITS)) : '0;
        o_result.mem_write_valid   = is_wr && i_policy == POLICY_WRITE_THROUGH;
        o_result.mem_write_address = o_result.mem_write_valid ? r_block : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clock    <= '0;
            for (int s = 0; s < ROWS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    r_valid[s][w] <= 1'b0;
                    r_dirty[s][w] <= 1'b0;
                end
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_UP;
                    end
                end
                S_UP: begin
                    r_state            <= S_IDLE;
                    r_valid[row][way]  <= 1'b1;
                    r_dirty[row][way]  <= new_dirty;
                    if (r_clock != 32'hFFFF_FFFF) begin
                        r_clock <= r_clock + 32'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op    <= i_op;
            r_set   <= i_set;
            r_tag   <= i_tag;
            r_block <= i_block;
            r_tag_row   <= mem_tag[IW'(i_set & IW'(ROWS - 1))];
            r_stamp_row <= mem_stamp[IW'(i_set & IW'(ROWS - 1))];
        end
        if (r_state == S_UP) begin
            mem_stamp[row][way] <= r_clock;
            if (!hit) begin
                mem_tag[row][way] <= r_tag;
            end
        end
    end

    // A result beat is only offered while the result queue has room.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> !i_out_full)
        else $error("result beat offered to a full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |=> (r_clock >= $past(r_clock)))
        else $error("use clock went backwards");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (o_result.fetch_valid != o_result.hit))
        else $error("fetch and hit disagree");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |=> (r_state == S_IDLE))
        else $error("update state held");
endmodule

### hdl/set_assoc_cache_lru_tags.sv
// Top level of the set-associative cache tag block with LRU replacement.
// Depends on sacl_pkg, sacl_front, sacl_back and sacl_fifo.
//
// Requests enter through a queue port: a beat is taken when push is high
// and full is low, carrying i_op and i_address. Results leave through a
// queue port: the oldest result is shown while empty is low and is taken
// when pop is high. Each request gives exactly one result beat.
// The write policy register is written over i_cfg_valid/o_cfg_ready,
// which is always ready; write it only while the block is idle.
// In the back end an item first has the set's tag and stamp row read from
// memory (S_IDLE), then the way chosen and the row written back (S_UP).
// The back end takes no new request until it has written back the row of
// the last one.
// Reset clears the valid and dirty bits, the use clock, the policy and
// both queues; tags and stamps need no clearing. When the receiver stalls
// the two-entry result queue fills, the back end waits, the request queue
// fills and full rises; nothing is lost.
module set_assoc_cache_lru_tags import sacl_pkg::*; #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic              i_op,
    input  logic [ADDR_W-1:0] i_address,
    output logic              empty,
    input  logic              pop,
    output logic              o_hit,
    output logic [1:0]        o_way_used,
    output logic              o_fetch_valid,
    output logic [ADDR_W-1:0] o_fetch_address,
    output logic              o_evict_valid,
    output logic [ADDR_W-1:0] o_evict_address,
    output logic              o_mem_write_valid,
    output logic [ADDR_W-1:0] o_mem_write_address,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_wdata
);
    localparam int SB0 = $clog2(SETS + 1) - 1;
    localparam int SB  = (SB0 > 12) ? 12 : SB0;
    localparam int IW  = (SB > 0) ? SB : 1;
    localparam int TW  = ADDR_W - OFFSET_BITS - SB;

    logic              r_policy;
    logic              q_empty;
    logic              q_pop;
    logic              f_op;
    logic [IW-1:0]     f_set;
    logic [TW-1:0]     f_tag;
    logic [ADDR_W-1:0] f_block;
    logic              res_full;
    logic              res_push;
    t_result           res_in;
    t_result           res_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= i_cfg_wdata;
        end
    end

    sacl_front #(.OFFSET_BITS(OFFSET_BITS), .SB(SB), .IW(IW), .TW(TW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_op      (i_op),
        .i_address (i_address),
        .o_full    (full),
        .i_pop     (q_pop),
        .o_empty   (q_empty),
        .o_op      (f_op),
        .o_set     (f_set),
        .o_tag     (f_tag),
        .o_block   (f_block)
    );

    sacl_back #(.OFFSET_BITS(OFFSET_BITS), .SB(SB), .IW(IW), .TW(TW), .WAYS(WAYS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_policy   (r_policy),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .i_op       (f_op),
        .i_set      (f_set),
        .i_tag      (f_tag),
        .i_block    (f_block),
        .i_out_full (res_full),
        .o_out_push (res_push),
        .o_result   (res_in)
    );

    sacl_fifo #(.WIDTH($bits(t_result))) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_hit               = res_out.hit;
    assign o_way_used          = res_out.way_used;
    assign o_fetch_valid       = res_out.fetch_valid;
    assign o_fetch_address     = res_out.fetch_address;
    assign o_evict_valid       = res_out.evict_valid;
    assign o_evict_address     = res_out.evict_address;
    assign o_mem_write_valid   = res_out.mem_write_valid;
    assign o_mem_write_address = res_out.mem_write_address;
endmodule

### tb/set_assoc_cache_lru_tags_tb.sv
// Self-checking testbench for the set-associative cache tag block with LRU replacement.
// Depends on sacl_pkg and the set_assoc_cache_lru_tags RTL; a built-in tag model predicts each result.
module set_assoc_cache_lru_tags_tb;
    import sacl_pkg::*;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 4;
    localparam int SET_BITS    = 6;
    localparam int LO          = OFFSET_BITS + SET_BITS;
    localparam int ENTRIES     = SETS * WAYS;
    localparam int STALL_LIMIT = 5000;
    localparam int N_RANDOM    = 640;
    localparam logic OP_READ   = 1'b0;
    localparam logic POLICY_WRITE_BACK = 1'b0;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic              i_op;
    logic [ADDR_W-1:0] i_address;
    logic              empty;
    logic              pop;
    logic              o_hit;
    logic [1:0]        o_way_used;
    logic              o_fetch_valid;
    logic [ADDR_W-1:0] o_fetch_address;
    logic              o_evict_valid;
    logic [ADDR_W-1:0] o_evict_address;
    logic              o_mem_write_valid;
    logic [ADDR_W-1:0] o_mem_write_address;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_wdata;

    set_assoc_cache_lru_tags #(
        .SETS(SETS), .WAYS(WAYS), .OFFSET_BITS(OFFSET_BITS)
    ) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_op(i_op), .i_address(i_address), .empty(empty), .pop(pop),
        .o_hit(o_hit), .o_way_used(o_way_used),
        .o_fetch_valid(o_fetch_valid), .o_fetch_address(o_fetch_address),
        .o_evict_valid(o_evict_valid), .o_evict_address(o_evict_address),
        .o_mem_write_valid(o_mem_write_valid),
        .o_mem_write_address(o_mem_write_address),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_wdata(i_cfg_wdata)
    );

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic              check_fixed;
        t_result           fixed;
    } t_row;

    logic [21:0]       tag_mem [ENTRIES];
    logic              line_valid [ENTRIES];
    logic              line_dirty [ENTRIES];
    logic [31:0]       line_stamp [ENTRIES];
    logic [31:0]       use_clock;
    logic              policy;
    t_result           pending_results [$];
    int                errors;
    int                idle_cycles;
    int                accepted_beats;
    int                popped_beats;
    int                hits_seen;
    int                evicts_seen;
    bit                pop_random;
    bit                push_random;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] next_stamp();
        logic [31:0] s;
        s = use_clock;
        if (use_clock != 32'hFFFF_FFFF) begin
            use_clock = use_clock + 1;
        end
        return s;
    endfunction

    function automatic t_result lookup_and_fill(logic op, logic [31:0] addr);
        t_result r;
        logic [5:0]  set;
        logic [21:0] tag;
        logic [31:0] block;
        logic [31:0] oldest;
        int          base;
        int          way;
        bit          found;
        r     = '0;
        set   = addr[LO-1:OFFSET_BITS];
        tag   = addr[31:LO];
        block = {addr[31:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
        base  = set * WAYS;
        way   = 0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && line_valid[base+w] && tag_mem[base+w] == tag) begin
                found = 1'b1;
                way = w;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            line_stamp[base+way] = next_stamp();
        end else begin
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (!line_valid[base+w]) begin
                    found = 1'b1;
                    way = w;
                end
            end
            if (!found) begin
                oldest = line_stamp[base];
                for (int w = 1; w < WAYS; w++) begin
                    if (line_stamp[base+w] < oldest) begin
                        oldest = line_stamp[base+w];
                        way = w;
                    end
                end
            end
            r.fetch_valid = 1'b1;
            r.fetch_address = block;
            if (line_valid[base+way] && line_dirty[base+way]) begin
                r.evict_valid = 1'b1;
                r.evict_address = {tag_mem[base+way], set, {OFFSET_BITS{1'b0}}};
            end
            tag_mem[base+way]    = tag;
            line_valid[base+way] = 1'b1;
            line_dirty[base+way] = 1'b0;
            line_stamp[base+way] = next_stamp();
        end
        if (op == OP_WRITE) begin
            if (policy == POLICY_WRITE_BACK) begin
                line_dirty[base+way] = 1'b1;
            end else begin
                r.mem_write_valid = 1'b1;
                r.mem_write_address = block;
            end
        end
        r.way_used = way[1:0];
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result side: pop, random once pop_random is set, checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                popped_beats++;
                if (pending_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    errors++;
                end else begin
                    t_result e;
                    e = pending_results.pop_front();
                    compare_field("hit", 32'(e.hit), 32'(o_hit));
                    compare_field("way_used", 32'(e.way_used), 32'(o_way_used));
                    compare_field("fetch_valid", 32'(e.fetch_valid), 32'(o_fetch_valid));
                    compare_field("fetch_address", e.fetch_address, o_fetch_address);
                    compare_field("evict_valid", 32'(e.evict_valid), 32'(o_evict_valid));
                    compare_field("evict_address", e.evict_address, o_evict_address);
                    compare_field("mem_write_valid", 32'(e.mem_write_valid),
                                  32'(o_mem_write_valid));
                    compare_field("mem_write_address", e.mem_write_address,
                                  o_mem_write_address);
                    hits_seen += o_hit;
                    evicts_seen += o_evict_valid;
                end
            end
            pop <= pop_random ? ($urandom_range(99) >= 35) : 1'b1;
        end
    end

    // Watchdog: cycles without any beat accepted on either side or any config write.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d results pending", pending_results.size());
                $display("set_assoc_cache_lru_tags regression: fail");
                $finish;
            end
        end
    end

    task automatic send_access(logic op, logic [31:0] addr, bit check_fixed, t_result fixed);
        t_result e;
        if (push_random) begin
            while ($urandom_range(99) < 35) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push      <= 1'b1;
        i_op      <= op;
        i_address <= addr;
        do @(posedge i_clk); while (full);
        accepted_beats++;
        e = lookup_and_fill(op, addr);
        if (check_fixed && e !== fixed) begin
            $error("table row for %h disagrees with prediction", addr);
            errors++;
        end
        pending_results = {pending_results, e};
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_policy(logic value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_wdata <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        policy = value;
    endtask

    function automatic t_result miss_result(logic [31:0] addr, logic [1:0] way);
        t_result r;
        r = '0;
        r.way_used = way;
        r.fetch_valid = 1'b1;
        r.fetch_address = {addr[31:4], 4'h0};
        return r;
    endfunction

    // Random address: few tags per set so that hits and LRU evictions occur.
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(9) < 8) begin
            a[31:LO] = 22'($urandom_range(5)) | (a[31] ? 22'h3F_FFF8 : 22'h0);
            a[LO-1:OFFSET_BITS] = (a[30] ? 6'h3F : 6'h0) | 6'($urandom_range(3));
        end
        return a;
    endfunction

    initial begin
        t_row rows [$];
        t_row row;
        errors = 0;
        accepted_beats = 0;
        popped_beats = 0;
        hits_seen = 0;
        evicts_seen = 0;
        pop_random = 1'b0;
        push_random = 1'b0;
        policy = POLICY_WRITE_BACK;
        use_clock = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            tag_mem[i] = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_stamp[i] = '0;
        end
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_op        <= OP_READ;
        i_address   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_wdata <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: read misses of two cold sets, then a read hit on the first block.
        row.check_fixed = 1'b1;
        row.op = OP_READ; row.address = 32'h0000_0000;
        row.fixed = miss_result(32'h0, 2'd0);
        rows = {rows, row};
        row.op = OP_READ; row.address = 32'hFFFF_FFFF;
        row.fixed = miss_result(32'hFFFF_FFFF, 2'd0);
        rows = {rows, row};
        row.op = OP_READ; row.address = 32'h0000_000F;
        row.fixed = '0;
        row.fixed.hit = 1'b1;
        rows = {rows, row};
        row.check_fixed = 1'b0;
        // Write five tags into set 1 so that the fifth evicts the dirty LRU line, then hit and evict again.
        for (int t = 0; t < 5; t++) begin
            row.op = OP_WRITE; row.address = {22'(t + 1), 6'd1, 4'h5};
            rows = {rows, row};
        end
        row.op = OP_READ; row.address = {22'd3, 6'd1, 4'h0}; rows = {rows, row};
        row.op = OP_WRITE; row.address = {22'h3F_FFFF, 6'd1, 4'hA}; rows = {rows, row};
        row.op = OP_READ; row.address = {22'd2, 6'd1, 4'h0}; rows = {rows, row};
        row.op = OP_WRITE; row.address = 32'hAAAA_5555; rows = {rows, row};
        row.op = OP_READ; row.address = 32'h5555_AAAA; rows = {rows, row};
        row.op = OP_WRITE; row.address = 32'hFFFF_FFF0; rows = {rows, row};
        foreach (rows[i]) begin
            send_access(rows[i].op, rows[i].address, rows[i].check_fixed, rows[i].fixed);
        end

        write_policy(POLICY_WRITE_THROUGH);
        send_access(OP_WRITE, 32'h8000_0013, 1'b0, '0);
        send_access(OP_WRITE, 32'h0000_0000, 1'b0, '0);
        send_access(OP_READ, 32'h8000_0010, 1'b0, '0);
        write_policy(POLICY_WRITE_BACK);

        // Unthrottled stretch, then random idling on both sides and policy switches.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 60) begin
                push_random = 1'b1;
                pop_random = 1'b1;
            end
            if (n == 300) begin
                write_policy(POLICY_WRITE_THROUGH);
            end
            if (n == 450) begin
                write_policy(POLICY_WRITE_BACK);
            end
            send_access(1'($urandom_range(1)), pick_address(), 1'b0, '0);
        end
        drain_results();

        $display("%0d accesses accepted, %0d results checked", accepted_beats, popped_beats);
        $display("%0d hits and %0d dirty evictions seen under both write policies",
                 hits_seen, evicts_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("set_assoc_cache_lru_tags regression: pass");
        end else begin
            $display("set_assoc_cache_lru_tags regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/sacl_pkg.sv
hdl/sacl_fifo.sv
hdl/sacl_front.sv
hdl/sacl_back.sv
hdl/set_assoc_cache_lru_tags.sv
tb/set_assoc_cache_lru_tags_tb.sv
